// ----- rtl/sorted_multiset_table_top_assert.svh -----
// Assertion macros for the sorted multiset table.
// Included by sorted_multiset_table_top; no other dependencies.
`ifndef SORTED_MULTISET_TABLE_TOP_ASSERT_SVH
`define SORTED_MULTISET_TABLE_TOP_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define SMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define SMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smt_pkg.sv -----
// Package for the sorted multiset table: sizes, codes and item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OUT_W  = 7;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_COUNT  = 2'd1,
        FN_DELETE = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] match_count;
        logic [OUT_W-1:0] occupancy;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/sorted_multiset_table_top.sv -----
// A refused insert, a no-op and any item on an empty store skip the scan and go
//   straight to the result; a stalled output holds the sequencer until its slot frees.
// One item at a time; scans step through the store over the single read port of
//   the store RAM (one entry read per cycle).
// Reset: synchronous, active low; clears count, FSM and output valid, not the store.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_multiset_table_top_assert.svh"

module sorted_multiset_table_top
    import smt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,  // wait for an item
        S_INS    = 7'b000_0010,  // insert: scan down from the top, shifting up
        S_INSPUT = 7'b000_0100,  // insert: value goes to entry 0
        S_CNT    = 7'b000_1000,  // count: scan up, tally equal entries
        S_DFIND  = 7'b001_0000,  // delete: scan up for the first match
        S_DSHIFT = 7'b010_0000,  // delete: shift the tail down one entry
        S_FIN    = 7'b100_0000   // hand the result to the output register
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [ADDR_W-1:0]        r_ptr, n_ptr;      // entry whose read data arrives now
    logic [CNT_W-1:0]         r_match, n_match;
    logic [1:0]               r_status, n_status;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    // Store RAM ports
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     w_last;   // r_ptr is the top stored entry
    logic                     w_hit;    // read data equals the key
    logic                     w_ge;     // read data >= value, signed

    smt_ram #(
        .P_WIDTH(DATA_W),
        .P_DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign w_last = (CNT_W'(r_ptr) == (r_count - CNT_W'(1)));
    assign w_hit  = ($signed(ram_rdata) == r_val);
    assign w_ge   = ($signed(ram_rdata) >= r_val);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_match     = r_match;
        n_status    = r_status;
        n_val       = r_val;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        // Output slot empties when taken; reloaded below in S_FIN.
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val    = i_in.value;
                    n_match  = '0;
                    n_status = ST_OK;
                    n_state  = S_FIN;
                    case (i_in.func)
                        FN_INSERT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                // empty store: write straight to entry 0
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = i_in.value;
                                n_count   = r_count + CNT_W'(1);
                            end else begin
                                ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                                n_ptr     = ADDR_W'(r_count - CNT_W'(1));
                                n_state   = S_INS;
                            end
                        end
                        FN_COUNT: begin
                            if (r_count != '0) begin
                                ram_raddr = '0;
                                n_ptr     = '0;
                                n_state   = S_CNT;
                            end
                        end
                        FN_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_raddr = '0;
                                n_ptr     = '0;
                                n_state   = S_DFIND;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr + ADDR_W'(1);
                if (w_ge) begin
                    // entry moves up one; keep scanning down
                    ram_wdata = ram_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_INSPUT;
                    end else begin
                        ram_raddr = r_ptr - ADDR_W'(1);
                        n_ptr     = r_ptr - ADDR_W'(1);
                    end
                end else begin
                    // smaller entry found: the value lands just above it
                    ram_wdata = r_val;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = S_FIN;
                end
            end

            S_INSPUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_val;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_FIN;
            end

            S_CNT: begin
                if (w_hit) begin
                    n_match = r_match + CNT_W'(1);
                end
                if (w_last) begin
                    n_state = S_FIN;
                end else begin
                    ram_raddr = r_ptr + ADDR_W'(1);
                    n_ptr     = r_ptr + ADDR_W'(1);
                end
            end

            S_DFIND: begin
                if (w_hit && w_last) begin
                    // match is the top entry: nothing to shift
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end else if (w_last) begin
                    n_status = ST_MISSING;
                    n_state  = S_FIN;
                end else begin
                    ram_raddr = r_ptr + ADDR_W'(1);
                    n_ptr     = r_ptr + ADDR_W'(1);
                    if (w_hit) begin
                        n_state = S_DSHIFT;
                    end
                end
            end

            S_DSHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (w_last) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end else begin
                    ram_raddr = r_ptr + ADDR_W'(1);
                    n_ptr     = r_ptr + ADDR_W'(1);
                end
            end

            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.match_count = OUT_W'(r_match);
                    n_out.occupancy   = OUT_W'(r_count);
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_match  <= n_match;
        r_status <= n_status;
        r_val    <= n_val;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------- checks
    `SMT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(DEPTH), "entry count above DEPTH")
    `SMT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, r_state == S_INSPUT,
        r_count == $past(r_count) + CNT_W'(1), "insert at head did not bump count")
    `SMT_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n,
        r_state == S_CNT || r_state == S_DFIND || r_state == S_DSHIFT,
        CNT_W'(r_ptr) < r_count, "scan pointer past stored entries")
    `SMT_ASSERT_NOW(a_full_status, i_clk, i_rst_n,
        r_state == S_FIN && r_status == ST_FULL,
        r_count == CNT_W'(DEPTH), "full status with room left")

endmodule

`default_nettype wire

// ----- rtl/smt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smt_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 64
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]                           i_wdata,
    input  wire logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]                           o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- tb/sorted_multiset_table_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_multiset_table_top: random insert/count/delete traffic
// checked against a queue-based sorted multiset kept in a small scoreboard class.
// Depends on smt_pkg and the RTL of sorted_multiset_table_top.

module sorted_multiset_table_top_test;
    import smt_pkg::*;

    // Scoreboard: mirrors the sorted store as an ascending queue of ints and keeps
    // the results still owed by the block, oldest first.
    class multiset_scoreboard;
        int        held_values[$];
        t_out_item awaited[$];
        int        errors;
        int        results_seen;
        int        items_noted;
        int        full_hits;
        int        empty_hits;
        int        missing_hits;
        int        match_hits;
        int        peak_fill;

        function new();
            errors       = 0;
            results_seen = 0;
            items_noted  = 0;
            full_hits    = 0;
            empty_hits   = 0;
            missing_hits = 0;
            match_hits   = 0;
            peak_fill    = 0;
        endfunction

        // Apply one accepted item to the mirror and queue the result it must produce.
        function void note_accepted(t_in_item it);
            t_out_item res;
            int        key;
            int        pos;
            int        hits;
            key  = it.value;
            pos  = 0;
            hits = 0;
            res.status      = ST_OK;
            res.match_count = '0;
            case (t_func'(it.func))
                FN_INSERT: begin
                    if (held_values.size() >= DEPTH) begin
                        res.status = ST_FULL;
                        full_hits++;
                    end else begin
                        // Goes in front of the first entry >= key, so duplicates keep order.
                        while (pos < held_values.size() && held_values[pos] < key)
                            pos++;
                        held_values.insert(pos, key);
                    end
                end
                FN_COUNT: begin
                    foreach (held_values[i])
                        if (held_values[i] == key)
                            hits++;
                    res.match_count = OUT_W'(hits);
                    if (hits > 0)
                        match_hits++;
                end
                FN_DELETE: begin
                    if (held_values.size() == 0) begin
                        res.status = ST_EMPTY;
                        empty_hits++;
                    end else begin
                        while (pos < held_values.size() && held_values[pos] != key)
                            pos++;
                        if (pos >= held_values.size()) begin
                            res.status = ST_MISSING;
                            missing_hits++;
                        end else begin
                            held_values.delete(pos);
                        end
                    end
                end
                default: ;
            endcase
            res.occupancy = OUT_W'(held_values.size());
            if (held_values.size() > peak_fill)
                peak_fill = held_values.size();
            awaited.push_back(res);
            items_noted++;
        endfunction

        // Compare one accepted result with the oldest outstanding expectation.
        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result status=%0d match_count=%0d occupancy=%0d",
                         $time, got.status, got.match_count, got.occupancy);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.match_count !== want.match_count) begin
                $display("%0t: match_count mismatch, expected %0d, got %0d",
                         $time, want.match_count, got.match_count);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy mismatch, expected %0d, got %0d",
                         $time, want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_AT      = 500;   // result count at which the receiver holds off
    localparam int HOLD_CYCLES  = 800;   // long enough to back the block up into its input

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    multiset_scoreboard sb;

    sorted_multiset_table_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (both sides stalling their worst, plus the long
    // hold) is well under a fifth of this.
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    // Sender side. Each call may first idle with valid low (never while in a burst), then
    // presents one item at the falling edge and holds it until it is accepted.
    // When no idle is drawn, valid stays high and only the payload changes, so
    // valid gets exactly one assignment per step.
    bit send_burst;

    task automatic send_item(t_func fn, int val);
        t_in_item it;
        int       gap;
        it.func  = fn;
        it.value = val;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_accepted(it);
    endtask

    // Key choice: mostly small values so duplicates and hits are common, some
    // extremes, some full-range values so every bit toggles. When asked, most
    // keys are taken from what is stored right now so counts and deletes hit.
    function automatic int pick_value(bit from_store);
        int sel;
        sel = $urandom_range(0, 99);
        if (from_store && sb.held_values.size() > 0 && sel < 85)
            return sb.held_values[$urandom_range(0, sb.held_values.size() - 1)];
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return int'($urandom_range(0, 15)) - 8;
        if (sel < 67) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0001;
                default: return 32'h7FFF_FFFE;
            endcase
        end
        return $urandom();
    endfunction

    // Operation mix per phase: 0 fills toward full, 1 is mixed, 2 drains to empty.
    function automatic t_func pick_func(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return FN_NOP;
        case (phase)
            0:       return (roll < 82) ? FN_INSERT : (roll < 94) ? FN_COUNT : FN_DELETE;
            1:       return (roll < 40) ? FN_INSERT : (roll < 70) ? FN_COUNT : FN_DELETE;
            default: return (roll < 15) ? FN_INSERT : (roll < 30) ? FN_COUNT : FN_DELETE;
        endcase
    endfunction

    // Receiver side. May drop ready before each result (never in bursts),
    // and once holds it low for a long stretch while the sender keeps pushing.
    bit recv_burst;
    bit hold_done;

    initial begin : receiver
        int stall;
        recv_burst = 1'b0;
        hold_done  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (!hold_done && sb.results_seen >= HOLD_AT) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do
                @(posedge i_clk);
            while (!(o_out_valid && i_out_ready));
            sb.check_result(o_out);
        end
    end

    // Main sequence: reset, directed corner items, phased random traffic, drain.
    initial begin : stimulus
        int phase;
        int left_in_phase;
        t_func fn;
        sb          = new();
        send_burst  = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-store behavior: count returns zero, delete reports empty.
        send_item(FN_COUNT,  5);
        send_item(FN_DELETE, 5);
        send_item(FN_NOP,    32'hFFFF_FFFF);
        // Extremes and duplicates; ordering of equal values.
        send_item(FN_INSERT, 32'h7FFF_FFFF);
        send_item(FN_INSERT, 32'h8000_0000);
        send_item(FN_INSERT, 0);
        send_item(FN_INSERT, -1);
        send_item(FN_INSERT, 0);
        send_item(FN_INSERT, 32'h8000_0000);
        send_item(FN_INSERT, 32'h5555_5555);
        send_item(FN_INSERT, 32'hAAAA_AAAA);
        send_item(FN_COUNT,  0);
        send_item(FN_COUNT,  32'h8000_0000);
        send_item(FN_COUNT,  32'h7FFF_FFFF);
        send_item(FN_COUNT,  12345);
        // Missing key, first-match delete, delete at head and tail.
        send_item(FN_DELETE, 777);
        send_item(FN_DELETE, 0);
        send_item(FN_COUNT,  0);
        send_item(FN_DELETE, 32'h8000_0000);
        send_item(FN_DELETE, 32'h7FFF_FFFF);
        send_item(FN_DELETE, -1);
        send_item(FN_NOP,    32'hAAAA_AAAA);
        send_item(FN_NOP,    32'h5555_5555);
        send_item(FN_COUNT,  32'h8000_0000);

        // Random part: cycle fill / mixed / drain so the store repeatedly goes
        // full (insert refused) and empty (delete refused).
        phase         = 0;
        left_in_phase = 160;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (left_in_phase == 0) begin
                phase         = (phase + 1) % 3;
                left_in_phase = (phase == 0) ? 160 : (phase == 1) ? 120 : 170;
            end
            left_in_phase--;
            fn = pick_func(phase);
            send_item(fn, pick_value(fn == FN_COUNT || fn == FN_DELETE));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Let every owed result arrive, then idle a full scan to catch strays.
        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);

        $display("covered %0d items, %0d results; peak occupancy %0d, %0d counts with hits",
                 sb.items_noted, sb.results_seen, sb.peak_fill, sb.match_hits);
        $display("refusals: %0d full inserts, %0d empty deletes, %0d missing keys",
                 sb.full_hits, sb.empty_hits, sb.missing_hits);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/smt_pkg.sv
rtl/smt_ram.sv
rtl/sorted_multiset_table_top.sv
tb/sorted_multiset_table_top_test.sv
